// File: rtl/pbrm_pkg.sv
// Shared types, codes and constants for the packet buffer ring manager.
// Used by pbrm_ctrl, pbrm_dpath and packet_buffer_ring_manager; no dependencies.
package pbrm_pkg;

  // Buffer count; BUF_W and LEVEL_W below are fixed, not derived from it
  localparam int NUM_BUFS = 64;

  // Default sizing
  localparam int DEF_RX_SLOTS  = 64;
  localparam int DEF_TX_SLOTS  = 64;
  localparam int DEF_BUF_BYTES = 2048;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int LEN_W   = 12;
  localparam int BUF_W   = 6;
  localparam int STAT_W  = 3;
  localparam int LEVEL_W = 7;

  // Stream widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 3;

  // Header bytes added to receive lengths
  localparam int RX_HDR_ADJ = 14;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_FREE = 2'd2
  } pbrm_req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOBUF    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_LONG     = 3'd4,
    ST_FREE_OVF = 3'd5
  } pbrm_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } pbrm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming request beat
    logic commit;  // apply the request and load the result register
  } pbrm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // result register holds a beat not yet taken
  } pbrm_sts_t;

endpackage

// File: rtl/pbrm_ctrl.sv
// Request sequencer for the packet buffer ring manager.
// Depends on pbrm_pkg for state, command and status types.
module pbrm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  pbrm_pkg::pbrm_sts_t  sts,
  output pbrm_pkg::pbrm_cmd_t  cmd
);

  pbrm_pkg::pbrm_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: take a request, then commit once the result slot is free
  always_comb begin
    state_next = state;
    case (state)
      pbrm_pkg::S_IDLE: begin
        if (s_tvalid) state_next = pbrm_pkg::S_EXEC;
      end
      pbrm_pkg::S_EXEC: begin
        if (!sts.out_busy) state_next = pbrm_pkg::S_IDLE;
      end
      default: state_next = pbrm_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      pbrm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      pbrm_pkg::S_EXEC: begin
        cmd.commit = !sts.out_busy;
      end
      default: ;
    endcase
  end

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken before commit");

  a_commit_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> ($past(cmd.load) || $past(state) == pbrm_pkg::S_EXEC))
    else $error("commit without a captured request");

endmodule

// File: rtl/pbrm_dpath.sv
// Datapath: free stack, descriptor rings, checks and result register.
// Depends on pbrm_pkg; driven by pbrm_ctrl through pbrm_cmd_t.
module pbrm_dpath #(
  parameter int RX_SLOTS  = pbrm_pkg::DEF_RX_SLOTS,
  parameter int TX_SLOTS  = pbrm_pkg::DEF_TX_SLOTS,
  parameter int BUF_BYTES = pbrm_pkg::DEF_BUF_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pbrm_pkg::pbrm_cmd_t             cmd,
  output pbrm_pkg::pbrm_sts_t             sts,
  input  logic [pbrm_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [pbrm_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pbrm_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [pbrm_pkg::M_TUSER_W-1:0]  m_tuser
);

  localparam int NUM_BUFS = pbrm_pkg::NUM_BUFS;
  localparam int BW    = $clog2(NUM_BUFS);
  localparam int TW    = $clog2(NUM_BUFS + 1);
  localparam int RX_AW = $clog2(RX_SLOTS);
  localparam int TX_AW = $clog2(TX_SLOTS);
  localparam int LEN_W = pbrm_pkg::LEN_W;
  localparam int DW    = LEN_W + BW;
  localparam int ADJ_W = LEN_W + 1;

  // Captured request
  logic [pbrm_pkg::REQ_W-1:0] req_q;
  logic                       sel_q;
  logic [LEN_W-1:0]           plen_q;
  logic [pbrm_pkg::BUF_W-1:0] bin_q;

  // Free stack state; mark is the lowest top reached, entries below it never written
  logic [TW-1:0] top, top_next, top_m1, mark;
  logic [BW-1:0] stack_mem [NUM_BUFS];
  logic [BW-1:0] stack_rd;
  logic [BW-1:0] pop_buf;

  // Rings
  logic [RX_AW-1:0] rx_prod, rx_cons, rx_prod_inc, rx_cons_inc;
  logic [TX_AW-1:0] tx_prod, tx_cons, tx_prod_inc, tx_cons_inc;
  logic [DW-1:0]    rx_mem [RX_SLOTS];
  logic [DW-1:0]    tx_mem [TX_SLOTS];
  logic [DW-1:0]    rx_rd, tx_rd, deq_desc;

  // Checks and result
  logic [ADJ_W-1:0]           adj_len;
  logic                       too_long, ring_full, ring_empty, bin_bad;
  logic                       do_enq, do_deq, do_push;
  pbrm_pkg::pbrm_status_t     res_status;
  logic [pbrm_pkg::BUF_W-1:0] res_buf;
  logic [LEN_W-1:0]           res_len;

  // Result register
  logic [pbrm_pkg::STAT_W-1:0]  out_status;
  logic [pbrm_pkg::BUF_W-1:0]   out_buf;
  logic [LEN_W-1:0]             out_len;
  logic [pbrm_pkg::LEVEL_W-1:0] out_level;

  // Capture request beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= s_tuser[1:0];
      sel_q  <= s_tuser[2];
      plen_q <= s_tdata[LEN_W-1:0];
      bin_q  <= s_tdata[LEN_W +: pbrm_pkg::BUF_W];
    end
  end

  // Pointer arithmetic
  assign top_m1      = top - 1'b1;
  assign rx_prod_inc = (rx_prod == RX_AW'(RX_SLOTS - 1)) ? '0 : rx_prod + 1'b1;
  assign rx_cons_inc = (rx_cons == RX_AW'(RX_SLOTS - 1)) ? '0 : rx_cons + 1'b1;
  assign tx_prod_inc = (tx_prod == TX_AW'(TX_SLOTS - 1)) ? '0 : tx_prod + 1'b1;
  assign tx_cons_inc = (tx_cons == TX_AW'(TX_SLOTS - 1)) ? '0 : tx_cons + 1'b1;

  // Condition checks
  assign adj_len    = sel_q ? {1'b0, plen_q}
                            : {1'b0, plen_q} + ADJ_W'(pbrm_pkg::RX_HDR_ADJ);
  assign too_long   = 32'(adj_len) > 32'(BUF_BYTES);
  assign ring_full  = sel_q ? (tx_prod_inc == tx_cons) : (rx_prod_inc == rx_cons);
  assign ring_empty = sel_q ? (tx_cons == tx_prod) : (rx_cons == rx_prod);
  assign bin_bad    = 32'(bin_q) >= 32'(NUM_BUFS);
  assign deq_desc   = sel_q ? tx_rd : rx_rd;
  // Slots below the mark are never written; their index is used in place of the read
  assign pop_buf    = (top <= mark) ? top_m1[BW-1:0] : stack_rd;

  // Decide outcome
  always_comb begin
    res_status = pbrm_pkg::ST_OK;
    res_buf    = '0;
    res_len    = '0;
    do_enq     = 1'b0;
    do_deq     = 1'b0;
    do_push    = 1'b0;
    case (req_q)
      pbrm_pkg::REQ_ENQ: begin
        if (too_long) begin
          res_status = pbrm_pkg::ST_LONG;
        end else if (top == '0) begin
          res_status = pbrm_pkg::ST_NOBUF;
        end else if (ring_full) begin
          res_status = pbrm_pkg::ST_FULL;
        end else begin
          do_enq  = 1'b1;
          res_buf = pbrm_pkg::BUF_W'(pop_buf);
          res_len = adj_len[LEN_W-1:0];
        end
      end
      pbrm_pkg::REQ_DEQ: begin
        if (ring_empty) begin
          res_status = pbrm_pkg::ST_EMPTY;
        end else begin
          do_deq  = 1'b1;
          res_buf = pbrm_pkg::BUF_W'(deq_desc[BW-1:0]);
          res_len = deq_desc[DW-1:BW];
        end
      end
      pbrm_pkg::REQ_FREE: begin
        if (top == TW'(NUM_BUFS) || bin_bad) begin
          res_status = pbrm_pkg::ST_FREE_OVF;
        end else begin
          do_push = 1'b1;
          res_buf = bin_q;
        end
      end
      default: ;
    endcase
  end

  assign top_next = do_enq ? top_m1 : (do_push ? top + 1'b1 : top);

  // Commit control state
  always_ff @(posedge clk) begin
    if (rst) begin
      top     <= TW'(NUM_BUFS);
      mark    <= TW'(NUM_BUFS);
      rx_prod <= '0;
      rx_cons <= '0;
      tx_prod <= '0;
      tx_cons <= '0;
    end else if (cmd.commit) begin
      top <= top_next;
      if (do_enq && top_m1 < mark) mark <= top_m1;
      if (do_enq && !sel_q) rx_prod <= rx_prod_inc;
      if (do_enq &&  sel_q) tx_prod <= tx_prod_inc;
      if (do_deq && !sel_q) rx_cons <= rx_cons_inc;
      if (do_deq &&  sel_q) tx_cons <= tx_cons_inc;
    end
  end

  // Free stack memory: read the top entry every cycle, push on commit
  always_ff @(posedge clk) begin
    stack_rd <= stack_mem[top_m1[BW-1:0]];
    if (cmd.commit && do_push) stack_mem[top[BW-1:0]] <= BW'(bin_q);
  end

  // Receive ring memory: read at consumer, write at producer
  always_ff @(posedge clk) begin
    rx_rd <= rx_mem[rx_cons];
    if (cmd.commit && do_enq && !sel_q) rx_mem[rx_prod] <= {adj_len[LEN_W-1:0], pop_buf};
  end

  // Transmit ring memory
  always_ff @(posedge clk) begin
    tx_rd <= tx_mem[tx_cons];
    if (cmd.commit && do_enq && sel_q) tx_mem[tx_prod] <= {adj_len[LEN_W-1:0], pop_buf};
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_buf    <= res_buf;
      out_len    <= res_len;
      out_level  <= pbrm_pkg::LEVEL_W'(top_next);
    end
  end

  // Result valid: set on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign sts.out_busy = m_tvalid && !m_tready;
  assign m_tuser      = out_status;
  assign m_tdata      = {{(pbrm_pkg::M_TDATA_W - pbrm_pkg::LEVEL_W - LEN_W
                           - pbrm_pkg::BUF_W){1'b0}}, out_level, out_len, out_buf};

  a_mark_below_top: assert property (@(posedge clk) disable iff (rst)
    mark <= top && top <= TW'(NUM_BUFS))
    else $error("free stack mark or top out of range");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("commit over an untaken result");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

  a_pop_moves_top: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_enq) |=> top == $past(top_m1))
    else $error("enqueue did not pop the free stack");

endmodule

// File: rtl/packet_buffer_ring_manager.sv
// Packet buffer manager: LIFO free stack plus receive and transmit descriptor rings.
// Path: an accepted request beat is captured, then committed into the result register.
// One request at a time; a new one is taken only after the last commits, and the commit
// uses the registered reads of the stack and ring memories and waits while a result is untaken.
// Reset: synchronous rst empties both rings, marks all buffers free, drops m_tvalid.
// Memories need no clearing; requests are taken in the first cycle after reset.
module packet_buffer_ring_manager #(
  parameter int RX_SLOTS  = pbrm_pkg::DEF_RX_SLOTS,
  parameter int TX_SLOTS  = pbrm_pkg::DEF_TX_SLOTS,
  parameter int BUF_BYTES = pbrm_pkg::DEF_BUF_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pbrm_pkg::S_TDATA_W-1:0]  s_tdata,   // pkt_len[11:0], buf_in[17:12], zero
  input  logic [pbrm_pkg::S_TUSER_W-1:0]  s_tuser,   // req_type[1:0], ring_sel[2]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pbrm_pkg::M_TDATA_W-1:0]  m_tdata,   // buf_out[5:0], len_out[17:6],
                                                     // free_level[24:18], zero
  output logic [pbrm_pkg::M_TUSER_W-1:0]  m_tuser    // status[2:0]
);

  pbrm_pkg::pbrm_cmd_t cmd;
  pbrm_pkg::pbrm_sts_t sts;

  pbrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbrm_dpath #(
    .RX_SLOTS  (RX_SLOTS),
    .TX_SLOTS  (TX_SLOTS),
    .BUF_BYTES (BUF_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
